// ----- design/cst_pkg.sv -----
// cst_pkg: shared constants and widths for complex_soft_threshold
// no dependencies
`timescale 1ns / 1ps
package cst_pkg;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 16;
  localparam int THRESH_BITS        = 16;
endpackage

// ----- design/cst_sqrt_cell.sv -----
// cst_sqrt_cell: one restoring square-root step, one result bit per cell, registered
// depends on cst_pkg for nothing beyond widths passed in
`timescale 1ns / 1ps
module cst_sqrt_cell #(
  parameter int RW = 17,
  parameter int VW = 34,
  parameter int SW = 16,
  parameter int K  = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [VW-1:0] rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [SW-1:0] re_i,
  input  logic [SW-1:0] im_i,
  input  logic          last_i,
  output logic          vld_o,
  output logic [VW-1:0] rem_o,
  output logic [RW-1:0] root_o,
  output logic [SW-1:0] re_o,
  output logic [SW-1:0] im_o,
  output logic          last_o
);
  logic [VW+1:0] trial;
  logic [VW+1:0] cand;
  logic          fits;
  logic [VW-1:0] rem_nxt;
  logic [RW-1:0] root_nxt;

  // trial value (4*root+1) << 2k against remainder
  assign cand  = ({{(VW+2-RW){1'b0}}, root_i} << 2) | {{(VW+1){1'b0}}, 1'b1};
  assign trial = cand << (2*K);
  assign fits  = {2'b00, rem_i} >= trial;
  assign rem_nxt  = fits ? rem_i - trial[VW-1:0] : rem_i;
  assign root_nxt = fits ? ((root_i << 1) | {{(RW-1){1'b0}}, 1'b1}) : (root_i << 1);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
      re_o   <= re_i;
      im_o   <= im_i;
      last_o <= last_i;
    end
  end
endmodule

// ----- design/cst_div_cell.sv -----
// cst_div_cell: one restoring division step, one quotient bit per cell, registered
// standalone; widths passed in
`timescale 1ns / 1ps
module cst_div_cell #(
  parameter int NW = 17,
  parameter int QW = 17,
  parameter int SW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] rem_i,
  input  logic [NW-1:0] den_i,
  input  logic [QW-1:0] q_i,
  input  logic          bit_i,
  input  logic [SW-1:0] re_i,
  input  logic [SW-1:0] im_i,
  input  logic          last_i,
  output logic          vld_o,
  output logic [NW-1:0] rem_o,
  output logic [NW-1:0] den_o,
  output logic [QW-1:0] q_o,
  output logic [SW-1:0] re_o,
  output logic [SW-1:0] im_o,
  output logic          last_o
);
  logic [NW:0] sh;
  logic        fits;

  // shift in next numerator bit, subtract divisor if it fits
  assign sh   = {rem_i, bit_i};
  assign fits = sh >= {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= fits ? NW'(sh - {1'b0, den_i}) : sh[NW-1:0];
      den_o  <= den_i;
      q_o    <= {q_i[QW-2:0], fits};
      re_o   <= re_i;
      im_o   <= im_i;
      last_o <= last_i;
    end
  end
endmodule

// ----- design/complex_soft_threshold.sv -----
// complex_soft_threshold: top level, chain of square-root cells then division cells
// depends on cst_pkg, cst_sqrt_cell, cst_div_cell
`timescale 1ns / 1ps
// Soft-threshold shrinkage of complex samples. One sample is accepted every clock
// while the output is taken. The pipeline is an input register, a chain of one-bit
// square-root cells (SAMPLE_BITS cells), one-bit divider cells (GAIN_FRAC_BITS+1
// cells) and an output register. The whole chain stalls together when out_tready is
// low while out_tvalid is high; in_tready follows out_tready or a free output.
// Write the threshold only while no transaction is in flight.
module complex_soft_threshold #(
  parameter int SAMPLE_BITS    = cst_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = cst_pkg::GAIN_FRAC_BITS_DEF,
  localparam int SW  = SAMPLE_BITS,
  localparam int GW  = GAIN_FRAC_BITS + 1,
  localparam int VW  = 2*SW,
  localparam int RW  = SW + 1,
  localparam int NW  = RW + 1,
  localparam int IB  = ((2*SW + 1) + 7) / 8 * 8,
  localparam int OB  = ((2*SW + GW) + 7) / 8 * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cst_pkg::THRESH_BITS-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [IB-1:0]               in_tdata,   // in_re, in_im
  input  logic                        in_tlast,   // last_element
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OB-1:0]               out_tdata,  // out_re, out_im, shrink_gain
  output logic                        out_tlast   // last_out
);
  localparam int DC = GW;
  localparam int CW = (RW > cst_pkg::THRESH_BITS ? RW : cst_pkg::THRESH_BITS) + 1;
  logic [cst_pkg::THRESH_BITS-1:0] thr_r;
  logic en;
  assign en        = out_tready | ~out_tvalid;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= '0;
    else if (cfg_we) thr_r <= cfg_wdata;
  end

  // input stage: absolute values and sum of squares
  logic          v0_r, l0_r;
  logic [SW-1:0] re0_r, im0_r;
  logic [VW-1:0] sq0_r;
  logic signed [SW-1:0] sre, sim;
  logic [SW-1:0] are, aim;
  assign sre = in_tdata[SW-1:0];
  assign sim = in_tdata[2*SW-1:SW];
  assign are = sre[SW-1] ? SW'(-sre) : sre;
  assign aim = sim[SW-1] ? SW'(-sim) : sim;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      re0_r <= sre; im0_r <= sim; l0_r <= in_tlast;
      sq0_r <= VW'({1'b0, are} * {1'b0, are}) + VW'({1'b0, aim} * {1'b0, aim});
    end
  end

  // square-root chain, msb cell first
  logic          sv [SW+1];
  logic [VW-1:0] srem [SW+1];
  logic [RW-1:0] sroot [SW+1];
  logic [SW-1:0] sre_c [SW+1], sim_c [SW+1];
  logic          sl [SW+1];
  assign sv[0] = v0_r; assign srem[0] = sq0_r; assign sroot[0] = '0;
  assign sre_c[0] = re0_r; assign sim_c[0] = im0_r; assign sl[0] = l0_r;
  for (genvar i = 0; i < SW; i++) begin : g_sq
    cst_sqrt_cell #(.RW(RW), .VW(VW), .SW(SW), .K(SW-1-i)) u_cell (
      .clk, .rst_n, .en,
      .vld_i(sv[i]), .rem_i(srem[i]), .root_i(sroot[i]),
      .re_i(sre_c[i]), .im_i(sim_c[i]), .last_i(sl[i]),
      .vld_o(sv[i+1]), .rem_o(srem[i+1]), .root_o(sroot[i+1]),
      .re_o(sre_c[i+1]), .im_o(sim_c[i+1]), .last_o(sl[i+1]));
  end

  // reduction r = m - thr, divide (r << F) / m; r <= m so start with remainder r
  logic [RW-1:0] mag;
  logic          pos;
  assign mag = sroot[SW];
  assign pos = CW'(mag) > CW'(thr_r);

  logic          dv [DC+1];
  logic [NW-1:0] drem [DC+1], dden [DC+1];
  logic [GW-1:0] dq [DC+1];
  logic [SW-1:0] dre [DC+1], dim [DC+1];
  logic          dl [DC+1];
  logic [NW-1:0] red;
  assign red = pos ? NW'(CW'(mag) - CW'(thr_r)) : '0;
  assign dv[0] = sv[SW]; assign dq[0] = '0;
  // first cell shifts in red[0], so the chain starts from red >> 1
  assign drem[0] = red >> 1;
  assign dden[0] = pos ? {1'b0, mag} : {{(NW-1){1'b1}}, 1'b1};
  assign dre[0] = sre_c[SW]; assign dim[0] = sim_c[SW]; assign dl[0] = sl[SW];
  for (genvar j = 0; j < DC; j++) begin : g_dv
    cst_div_cell #(.NW(NW), .QW(GW), .SW(SW)) u_cell (
      .clk, .rst_n, .en,
      .vld_i(dv[j]), .rem_i(drem[j]), .den_i(dden[j]), .q_i(dq[j]),
      .bit_i(j == 0 ? red[0] : 1'b0),
      .re_i(dre[j]), .im_i(dim[j]), .last_i(dl[j]),
      .vld_o(dv[j+1]), .rem_o(drem[j+1]), .den_o(dden[j+1]), .q_o(dq[j+1]),
      .re_o(dre[j+1]), .im_o(dim[j+1]), .last_o(dl[j+1]));
  end

  // scaling stage: magnitude times gain, restore sign
  logic signed [SW-1:0] fre, fim;
  logic [SW-1:0] fare, faim;
  logic [SW+GW-1:0] pre, pim;
  logic [SW-1:0] mre, mim;
  assign fre = dre[DC]; assign fim = dim[DC];
  assign fare = fre[SW-1] ? SW'(-fre) : fre;
  assign faim = fim[SW-1] ? SW'(-fim) : fim;
  assign pre = {{GW{1'b0}}, fare} * {{SW{1'b0}}, dq[DC]};
  assign pim = {{GW{1'b0}}, faim} * {{SW{1'b0}}, dq[DC]};
  assign mre = pre[GAIN_FRAC_BITS +: SW];
  assign mim = pim[GAIN_FRAC_BITS +: SW];

  logic [SW-1:0] ore_r, oim_r;
  logic [GW-1:0] og_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= dv[DC];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ore_r <= fre[SW-1] ? SW'(-mre) : mre;
      oim_r <= fim[SW-1] ? SW'(-mim) : mim;
      og_r  <= dq[DC];
      out_tlast <= dl[DC];
    end
  end
  assign out_tdata = OB'({og_r, oim_r, ore_r});
endmodule

// ----- design/cst_checker.sv -----
// cst_checker: port-level assertions for complex_soft_threshold, bound to the top level
// depends on complex_soft_threshold ports only
`timescale 1ns / 1ps
module cst_checker #(
  parameter int OB = 56,
  parameter int SW = 16,
  parameter int GF = 16
) (
  input logic clk, rst_n, in_tready, out_tvalid, out_tready, out_tlast,
  input logic [OB-1:0] out_tdata
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");
  // gain never above one
  a_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2*SW+GF] |-> out_tdata[2*SW +: GF] == '0)
    else $error("gain above one");
  // zero gain gives zero outputs
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2*SW +: GF+1] == '0 |-> out_tdata[2*SW-1:0] == '0)
    else $error("nonzero output with zero gain");
  // input is never refused while output is free
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("stall with empty output");
endmodule

bind complex_soft_threshold cst_checker #(.OB(OB), .SW(SW), .GF(GAIN_FRAC_BITS))
  u_cst_checker (.clk, .rst_n, .in_tready, .out_tvalid, .out_tready,
  .out_tlast, .out_tdata);
